// ===== design/rte_pkg.sv =====
// Package with shared constants of the reading time estimator.
`default_nettype none
package rte_pkg;
    localparam int OP_W = 3;
    localparam int WIDX_W = 16;
    localparam int BONUS_W = 16;
    localparam int RANGE_W = 17;
    localparam int RES_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;
    localparam int WC_W = 17;
    localparam int WPM_W = 16;

    localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
    localparam logic [OP_W-1:0] OP_START = 3'd1;
    localparam logic [OP_W-1:0] OP_STEP = 3'd2;
    localparam logic [OP_W-1:0] OP_QUERY = 3'd3;
    localparam logic [OP_W-1:0] OP_INVAL = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_WORD_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WPM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCURATE = 2'd2;

    localparam logic [WPM_W-1:0] MS_PER_MIN = 16'd60000;
    localparam logic [WC_W-1:0] WC_RESET = 17'd0;
    localparam logic [WPM_W-1:0] WPM_RESET = 16'd300;
endpackage
`default_nettype wire

// ===== design/rte_req_if.sv =====
// Request channel interface of the reading time estimator.
`default_nettype none
interface rte_req_if;
    logic valid;
    logic ready;
    logic [rte_pkg::OP_W-1:0] op;
    logic [rte_pkg::WIDX_W-1:0] word_index;
    logic [rte_pkg::BONUS_W-1:0] bonus_ms;
    logic [rte_pkg::RANGE_W-1:0] start_index;
    logic [rte_pkg::RANGE_W-1:0] end_index;
    modport source (output valid, op, word_index, bonus_ms, start_index, end_index,
                    input ready);
    modport sink (input valid, op, word_index, bonus_ms, start_index, end_index,
                  output ready);
endinterface
`default_nettype wire

// ===== design/rte_rsp_if.sv =====
// Result channel interface of the reading time estimator.
`default_nettype none
interface rte_rsp_if;
    logic valid;
    logic ready;
    logic [rte_pkg::RES_W-1:0] remaining_ms;
    logic cache_valid;
    logic build_busy;
    modport source (output valid, remaining_ms, cache_valid, build_busy, input ready);
    modport sink (input valid, remaining_ms, cache_valid, build_busy, output ready);
endinterface
`default_nettype wire

// ===== design/rte_cfg_if.sv =====
// Register write channel interface of the reading time estimator.
`default_nettype none
interface rte_cfg_if;
    logic valid;
    logic ready;
    logic [rte_pkg::CFG_IDX_W-1:0] index;
    logic [rte_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/range_time_estimate_block_prefix.sv =====
// Top level of the reading time estimator with its sequencer and stores.
// Items arrive on req and each one returns exactly one result on rsp; registers
// are written on cfg, which is always ready; cfg must be used only while idle,
// which the block itself does not enforce. Op 0 writes a word bonus, op 1 starts
// a table build when accurate mode is on and the word count is not zero, op 2
// sums up to BLOCKS_PER_STEP blocks into the block prefix table or drops the
// build when the mode or word count has changed, op 3 queries a word range, op 4
// clears the table. One item is handled at a time: req is ready only while the
// sequencer is idle. A build step sums its blocks with one word store read per
// cycle. A query over a non-empty range at a nonzero wpm runs the bit-serial
// divide and, in accurate mode with a valid table, its bonus summation alongside,
// which reads up to two partial blocks (at most 2 * BLOCK_WORDS - 2 words)
// through the single store read port, or every word of the range when the range
// spans no full block or reaches past the built table. Results wait in an output
// register while rsp is stalled; the next request is taken meanwhile but its
// result waits. Reset clears the table state and registers; the word store holds
// no reset value and needs no clearing pass. BLOCK_WORDS must be a power of two.
`default_nettype none
module range_time_estimate_block_prefix #(
    parameter int MAX_WORDS = 65536,
    parameter int BLOCK_WORDS = 256,
    parameter int BLOCKS_PER_STEP = 1
) (
    input  wire logic clk,
    input  wire logic rst_n,
    rte_cfg_if.sink cfg,
    rte_req_if.sink req,
    rte_rsp_if.source rsp
);
    localparam int NW = $clog2(MAX_WORDS + 1);
    localparam int AW = $clog2(MAX_WORDS);
    localparam int XW = ((NW > rte_pkg::WC_W) ? NW : rte_pkg::WC_W) + 1;
    localparam int SH = $clog2(BLOCK_WORDS);
    localparam int TD = (MAX_WORDS + BLOCK_WORDS - 1) / BLOCK_WORDS + 1;
    localparam int BW = $clog2(TD);
    localparam int DW = $clog2(BLOCKS_PER_STEP + 1);
    localparam int PW = NW + rte_pkg::WPM_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_QPREP = 4'd2;
    localparam logic [3:0] S_QPLAN = 4'd3;
    localparam logic [3:0] S_SUM = 4'd4;
    localparam logic [3:0] S_TRD0 = 4'd5;
    localparam logic [3:0] S_TRD1 = 4'd6;
    localparam logic [3:0] S_TRD2 = 4'd7;
    localparam logic [3:0] S_BBLK = 4'd8;
    localparam logic [3:0] S_WDIV = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    localparam logic [1:0] RET_BUILD = 2'd0;
    localparam logic [1:0] RET_HEAD = 2'd1;
    localparam logic [1:0] RET_TAIL = 2'd2;

    logic [15:0] store [MAX_WORDS];
    logic [31:0] tbl [TD];

    logic [rte_pkg::WC_W-1:0] wc_reg;
    logic [rte_pkg::WPM_W-1:0] wpm_reg;
    logic acc_mode_reg;

    logic [3:0] state_reg, state_next;
    logic [1:0] ret_reg, ret_next;
    logic [rte_pkg::OP_W-1:0] op_reg;
    logic [NW-1:0] s_reg, s_next, e_reg, e_next;
    logic [NW-1:0] cur_reg, cur_next, hi_reg, hi_next;
    logic [BW-1:0] ff_reg, ff_next, le_reg, le_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] res_reg, res_next;
    logic pend_reg, pend_next;
    logic tv_reg, tv_next, bld_reg, bld_next;
    logic [BW-1:0] nb_reg, nb_next, bbc_reg, bbc_next, tbc_reg, tbc_next;
    logic [NW-1:0] bwc_reg, bwc_next;
    logic [31:0] rs_reg, rs_next;
    logic [DW-1:0] done_reg, done_next;
    logic out_v_reg;
    logic [31:0] out_ms_reg;
    logic out_cv_reg, out_bb_reg;

    logic [15:0] wrd_reg;
    logic [31:0] trd_reg;
    logic tbl_we;
    logic [BW-1:0] tbl_waddr;
    logic [31:0] tbl_wdata;
    logic [BW-1:0] tbl_raddr;
    logic word_rd;
    logic req_fire;

    logic [NW-1:0] n_eff;
    logic div_start, div_done;
    logic [PW-1:0] dividend, quotient;
    logic [NW:0] blk_end, head_end, ceil_sum;

    assign req_fire = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    always_comb
    begin
        if (XW'(wc_reg) < XW'(MAX_WORDS))
            n_eff = NW'(wc_reg);
        else
            n_eff = NW'(MAX_WORDS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg <= rte_pkg::WC_RESET;
            wpm_reg <= rte_pkg::WPM_RESET;
            acc_mode_reg <= 1'b1;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                rte_pkg::REG_WORD_COUNT: wc_reg <= cfg.data;
                rte_pkg::REG_WPM: wpm_reg <= cfg.data[rte_pkg::WPM_W-1:0];
                rte_pkg::REG_ACCURATE: acc_mode_reg <= cfg.data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire && req.op == rte_pkg::OP_WRITE
            && XW'(req.word_index) < XW'(MAX_WORDS))
            store[AW'(req.word_index)] <= req.bonus_ms;
        if (word_rd)
            wrd_reg <= store[cur_reg[AW-1:0]];
        if (tbl_we)
            tbl[tbl_waddr] <= tbl_wdata;
        trd_reg <= tbl[tbl_raddr];
        if (req_fire)
            op_reg <= req.op;
    end

    assign dividend = PW'(e_reg - s_reg) * PW'(rte_pkg::MS_PER_MIN);

    rte_div #(.PW(PW)) u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .dividend(dividend),
        .divisor(wpm_reg),
        .done(div_done),
        .quotient(quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        ret_next = ret_reg;
        s_next = s_reg;
        e_next = e_reg;
        cur_next = cur_reg;
        hi_next = hi_reg;
        ff_next = ff_reg;
        le_next = le_reg;
        acc_next = acc_reg;
        res_next = res_reg;
        pend_next = pend_reg;
        tv_next = tv_reg;
        bld_next = bld_reg;
        nb_next = nb_reg;
        bbc_next = bbc_reg;
        tbc_next = tbc_reg;
        bwc_next = bwc_reg;
        rs_next = rs_reg;
        done_next = done_reg;
        tbl_we = 1'b0;
        tbl_waddr = nb_reg;
        tbl_wdata = rs_reg;
        tbl_raddr = ff_reg;
        word_rd = 1'b0;
        div_start = 1'b0;
        blk_end = {1'b0, nb_reg, SH'(0)} + (NW + 1)'(BLOCK_WORDS);
        head_end = {1'b0, ff_reg, SH'(0)};
        ceil_sum = {1'b0, n_eff} + (NW + 1)'(BLOCK_WORDS - 1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    res_next = '0;
                    s_next = (XW'(req.start_index) > XW'(n_eff)) ? n_eff
                                                                : NW'(req.start_index);
                    e_next = (XW'(req.end_index) > XW'(n_eff)) ? n_eff
                                                              : NW'(req.end_index);
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = S_DONE;
                priority case (op_reg)
                    rte_pkg::OP_START, rte_pkg::OP_INVAL:
                    begin
                        tv_next = 1'b0;
                        bld_next = 1'b0;
                        bwc_next = '0;
                        bbc_next = '0;
                        nb_next = '0;
                        rs_next = '0;
                        if (op_reg == rte_pkg::OP_START && acc_mode_reg && n_eff != '0)
                        begin
                            bld_next = 1'b1;
                            bwc_next = n_eff;
                            bbc_next = BW'(ceil_sum >> SH);
                            tbc_next = BW'(ceil_sum >> SH);
                        end
                    end
                    rte_pkg::OP_STEP:
                    begin
                        if (bld_reg)
                        begin
                            if (!acc_mode_reg || bwc_reg != n_eff)
                            begin
                                tv_next = 1'b0;
                                bld_next = 1'b0;
                                bwc_next = '0;
                                bbc_next = '0;
                                nb_next = '0;
                                rs_next = '0;
                            end
                            else
                            begin
                                done_next = '0;
                                state_next = S_BBLK;
                            end
                        end
                    end
                    rte_pkg::OP_QUERY:
                    begin
                        state_next = S_QPREP;
                    end
                    default: ;
                endcase
            end
            S_QPREP:
            begin
                if (n_eff == '0 || wpm_reg == '0 || e_reg <= s_reg)
                    state_next = S_DONE;
                else
                begin
                    div_start = 1'b1;
                    ff_next = BW'(({1'b0, s_reg} + (NW + 1)'(BLOCK_WORDS - 1)) >> SH);
                    le_next = BW'(e_reg >> SH);
                    acc_next = '0;
                    state_next = S_QPLAN;
                end
            end
            S_QPLAN:
            begin
                pend_next = 1'b0;
                cur_next = s_reg;
                if (!(acc_mode_reg && tv_reg))
                    state_next = S_WDIV;
                else if (ff_reg < le_reg && le_reg <= tbc_reg)
                begin
                    hi_next = (head_end > {1'b0, e_reg}) ? e_reg : NW'(head_end);
                    ret_next = RET_HEAD;
                    state_next = S_SUM;
                end
                else
                begin
                    hi_next = e_reg;
                    ret_next = RET_TAIL;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (pend_reg)
                    acc_next = acc_reg + 32'(wrd_reg);
                if (cur_reg < hi_reg)
                begin
                    word_rd = 1'b1;
                    cur_next = cur_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        unique case (ret_reg)
                            RET_BUILD:
                            begin
                                rs_next = acc_reg;
                                nb_next = nb_reg + 1'b1;
                                done_next = done_reg + 1'b1;
                                state_next = S_BBLK;
                            end
                            RET_HEAD: state_next = S_TRD0;
                            RET_TAIL: state_next = S_WDIV;
                            default: state_next = S_WDIV;
                        endcase
                    end
                end
            end
            S_TRD0:
            begin
                tbl_raddr = ff_reg;
                state_next = S_TRD1;
            end
            S_TRD1:
            begin
                acc_next = acc_reg - trd_reg;
                tbl_raddr = le_reg;
                state_next = S_TRD2;
            end
            S_TRD2:
            begin
                acc_next = acc_reg + trd_reg;
                cur_next = NW'({le_reg, SH'(0)});
                hi_next = e_reg;
                pend_next = 1'b0;
                ret_next = RET_TAIL;
                state_next = S_SUM;
            end
            S_BBLK:
            begin
                if (nb_reg < bbc_reg && done_reg < DW'(BLOCKS_PER_STEP))
                begin
                    tbl_we = 1'b1;
                    tbl_waddr = nb_reg;
                    tbl_wdata = rs_reg;
                    cur_next = NW'({nb_reg, SH'(0)});
                    hi_next = (blk_end > {1'b0, bwc_reg}) ? bwc_reg : NW'(blk_end);
                    acc_next = rs_reg;
                    pend_next = 1'b0;
                    ret_next = RET_BUILD;
                    state_next = S_SUM;
                end
                else
                begin
                    if (nb_reg >= bbc_reg)
                    begin
                        tbl_we = 1'b1;
                        tbl_waddr = bbc_reg;
                        tbl_wdata = rs_reg;
                        tv_next = 1'b1;
                        bld_next = 1'b0;
                        bwc_next = '0;
                        bbc_next = '0;
                        nb_next = '0;
                        rs_next = '0;
                    end
                    state_next = S_DONE;
                end
            end
            S_WDIV:
            begin
                if (div_done)
                begin
                    res_next = 32'(quotient) + acc_reg;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_v_reg || rsp.ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg <= RET_BUILD;
            pend_reg <= 1'b0;
            tv_reg <= 1'b0;
            bld_reg <= 1'b0;
            nb_reg <= '0;
            bbc_reg <= '0;
            tbc_reg <= '0;
            bwc_reg <= '0;
            rs_reg <= '0;
            done_reg <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            pend_reg <= pend_next;
            tv_reg <= tv_next;
            bld_reg <= bld_next;
            nb_reg <= nb_next;
            bbc_reg <= bbc_next;
            tbc_reg <= tbc_next;
            bwc_reg <= bwc_next;
            rs_reg <= rs_next;
            done_reg <= done_next;
            if (state_reg == S_DONE && (!out_v_reg || rsp.ready))
                out_v_reg <= 1'b1;
            else if (rsp.ready)
                out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        e_reg <= e_next;
        cur_reg <= cur_next;
        hi_reg <= hi_next;
        ff_reg <= ff_next;
        le_reg <= le_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
        if (state_reg == S_DONE && (!out_v_reg || rsp.ready))
        begin
            out_ms_reg <= res_reg;
            out_cv_reg <= tv_reg;
            out_bb_reg <= bld_reg;
        end
    end

    assign rsp.valid = out_v_reg;
    assign rsp.remaining_ms = out_ms_reg;
    assign rsp.cache_valid = out_cv_reg;
    assign rsp.build_busy = out_bb_reg;

`ifndef SYNTH
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> state_reg != S_IDLE)
        else $error("sequencer did not leave idle after a request");
    a_valid_not_building: assert property (@(posedge clk) disable iff (!rst_n)
        !(tv_reg && bld_reg))
        else $error("table valid while a build is running");
    a_block_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        bld_reg |-> nb_reg <= bbc_reg)
        else $error("build block index beyond block count");
    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> state_reg == S_QPLAN)
        else $error("divider started outside query planning");
`endif
endmodule
`default_nettype wire

// ===== design/rte_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module rte_div #(
    parameter int PW = 33
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic [PW-1:0] dividend,
    input  wire logic [rte_pkg::WPM_W-1:0] divisor,
    output logic done,
    output logic [PW-1:0] quotient
);
    localparam int CW = $clog2(PW + 1);

    logic [PW-1:0] quo_reg;
    logic [rte_pkg::WPM_W-1:0] rem_reg;
    logic [rte_pkg::WPM_W-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic busy_reg;
    logic done_reg;
    logic [rte_pkg::WPM_W:0] trial;
    logic take;

    always_comb
    begin
        trial = {rem_reg, quo_reg[PW-1]};
        take = trial >= {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg <= CW'(PW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[PW-2:0], take};
            rem_reg <= take ? rte_pkg::WPM_W'(trial - {1'b0, dvs_reg})
                            : trial[rte_pkg::WPM_W-1:0];
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

// ===== dv/range_time_estimate_block_prefix_test.sv =====
// Self-checking testbench of the reading time estimator with its block prefix table.
`timescale 1ns / 1ps
module range_time_estimate_block_prefix_test;
    localparam logic [rte_pkg::OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [rte_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;
    localparam int STORE_WORDS = 65536;
    localparam int BLK = 256;
    localparam int TAB_DEPTH = STORE_WORDS / BLK + 1;
    localparam int FILLED_WORDS = 800;
    localparam int LONG_HOLD = 400;

    typedef struct packed {
        logic [rte_pkg::RES_W-1:0] ms;
        logic cv;
        logic bb;
    } estimate_t;

    typedef struct {
        bit is_cfg;
        logic [rte_pkg::CFG_IDX_W-1:0] idx;
        logic [rte_pkg::CFG_DATA_W-1:0] data;
        logic [rte_pkg::OP_W-1:0] op;
        logic [rte_pkg::WIDX_W-1:0] widx;
        logic [rte_pkg::BONUS_W-1:0] bonus;
        logic [rte_pkg::RANGE_W-1:0] s;
        logic [rte_pkg::RANGE_W-1:0] e;
        bit typed;
        estimate_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    rte_cfg_if cfg_bus();
    rte_req_if req_bus();
    rte_rsp_if rsp_bus();

    range_time_estimate_block_prefix u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_bus),
        .req(req_bus),
        .rsp(rsp_bus)
    );

    // Predictor state.
    logic [rte_pkg::BONUS_W-1:0] bonus_mem [0:STORE_WORDS-1];
    logic [31:0] prefix_tab [0:TAB_DEPTH-1];
    logic [rte_pkg::WC_W-1:0] cur_wc;
    logic [rte_pkg::WPM_W-1:0] cur_wpm;
    bit cur_acc;
    bit tab_valid;
    bit building;
    int unsigned next_blk;
    logic [31:0] run_sum;
    int unsigned built_words;
    int unsigned built_blocks;
    int unsigned tab_len;

    estimate_t pending_estimates [$];
    int fail_count;
    bit quiet;
    bit hold_pending;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int unsigned eff_words();
        return (cur_wc > STORE_WORDS) ? STORE_WORDS : cur_wc;
    endfunction

    function automatic void stop_build();
        building = 0;
        built_words = 0;
        built_blocks = 0;
        next_blk = 0;
        run_sum = 0;
    endfunction

    function automatic void clear_table();
        stop_build();
        tab_valid = 0;
        for (int i = 0; i < TAB_DEPTH; i++)
            prefix_tab[i] = 0;
        tab_len = 0;
    endfunction

    function automatic logic [31:0] bonus_sum(int unsigned from, int unsigned to);
        logic [31:0] acc;
        acc = 0;
        for (int unsigned i = from; i < to && i < STORE_WORDS; i++)
            acc += bonus_mem[i];
        return acc;
    endfunction

    function automatic logic [31:0] range_estimate(int unsigned s, int unsigned e);
        int unsigned n;
        int unsigned ff;
        int unsigned le;
        int unsigned he;
        logic [31:0] base;
        logic [31:0] bon;
        n = eff_words();
        if (n == 0 || cur_wpm == 0)
            return 0;
        if (s > n)
            s = n;
        if (e > n)
            e = n;
        if (e <= s)
            return 0;
        base = 32'((64'(e - s) * 64'd60000) / 64'(cur_wpm));
        if (!cur_acc || !tab_valid)
            return base;
        ff = (s + BLK - 1) / BLK;
        le = e / BLK;
        if (ff < le && le < tab_len && le < TAB_DEPTH)
        begin
            he = ff * BLK;
            if (he > e)
                he = e;
            bon = bonus_sum(s, he);
            bon += prefix_tab[le] - prefix_tab[ff];
            bon += bonus_sum(le * BLK, e);
        end
        else
        begin
            bon = bonus_sum(s, e);
        end
        return base + bon;
    endfunction

    function automatic estimate_t apply_request(logic [rte_pkg::OP_W-1:0] op,
                                                logic [rte_pkg::WIDX_W-1:0] widx,
                                                logic [rte_pkg::BONUS_W-1:0] bon,
                                                logic [rte_pkg::RANGE_W-1:0] s,
                                                logic [rte_pkg::RANGE_W-1:0] e);
        estimate_t r;
        int unsigned n;
        int unsigned lo;
        int unsigned hi;
        r.ms = 0;
        case (op)
            rte_pkg::OP_WRITE: bonus_mem[widx] = bon;
            rte_pkg::OP_START:
            begin
                clear_table();
                n = eff_words();
                if (cur_acc && n != 0)
                begin
                    built_words = n;
                    built_blocks = (n + BLK - 1) / BLK;
                    tab_len = built_blocks + 1;
                    building = 1;
                end
            end
            rte_pkg::OP_STEP:
            begin
                if (building)
                begin
                    if (!cur_acc || built_words != eff_words())
                    begin
                        clear_table();
                    end
                    else
                    begin
                        if (next_blk < built_blocks)
                        begin
                            lo = next_blk * BLK;
                            hi = lo + BLK;
                            if (hi > built_words)
                                hi = built_words;
                            prefix_tab[next_blk] = run_sum;
                            run_sum += bonus_sum(lo, hi);
                            next_blk++;
                        end
                        if (next_blk >= built_blocks)
                        begin
                            prefix_tab[built_blocks] = run_sum;
                            tab_valid = 1;
                            stop_build();
                        end
                    end
                end
            end
            rte_pkg::OP_QUERY: r.ms = range_estimate(s, e);
            rte_pkg::OP_INVAL: clear_table();
            default: ;
        endcase
        r.cv = tab_valid;
        r.bb = building;
        return r;
    endfunction

    task automatic write_reg(input logic [rte_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rte_pkg::CFG_DATA_W-1:0] data);
        cfg_bus.index <= idx;
        cfg_bus.data <= data;
        cfg_bus.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (idx)
            rte_pkg::REG_WORD_COUNT: cur_wc = data;
            rte_pkg::REG_WPM: cur_wpm = data[rte_pkg::WPM_W-1:0];
            rte_pkg::REG_ACCURATE: cur_acc = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic send_req(input logic [rte_pkg::OP_W-1:0] op,
                            input logic [rte_pkg::WIDX_W-1:0] widx,
                            input logic [rte_pkg::BONUS_W-1:0] bon,
                            input logic [rte_pkg::RANGE_W-1:0] s,
                            input logic [rte_pkg::RANGE_W-1:0] e, input bit typed,
                            input estimate_t want);
        estimate_t got;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        req_bus.op <= op;
        req_bus.word_index <= widx;
        req_bus.bonus_ms <= bon;
        req_bus.start_index <= s;
        req_bus.end_index <= e;
        req_bus.valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_bus.ready);
        got = apply_request(op, widx, bon, s, e);
        pending_estimates.push_back(typed ? want : got);
        @(negedge clk);
    endtask

    task automatic drain();
        req_bus.valid <= 1'b0;
        while (pending_estimates.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic send_rand(input logic [rte_pkg::OP_W-1:0] op);
        logic [rte_pkg::RANGE_W-1:0] s;
        logic [rte_pkg::RANGE_W-1:0] e;
        logic [rte_pkg::WIDX_W-1:0] w;
        int unsigned n;
        n = eff_words();
        if ($urandom_range(0, 4) == 0)
        begin
            s = rte_pkg::RANGE_W'($urandom);
            e = rte_pkg::RANGE_W'($urandom);
        end
        else
        begin
            s = rte_pkg::RANGE_W'($urandom_range(0, n + 20));
            e = rte_pkg::RANGE_W'($urandom_range(0, n + 20));
            if ($urandom_range(0, 2) != 0 && e < s)
                {s, e} = {e, s};
        end
        w = ($urandom_range(0, 1) == 0) ? rte_pkg::WIDX_W'($urandom_range(0, FILLED_WORDS - 1))
                                        : rte_pkg::WIDX_W'($urandom);
        send_req(op, w, rte_pkg::BONUS_W'($urandom), s, e, 0, '0);
    endtask

    always @(posedge clk)
    begin
        estimate_t exp_r;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (pending_estimates.size() == 0)
            begin
                $error("result with no request outstanding");
                fail_count++;
            end
            else
            begin
                exp_r = pending_estimates.pop_front();
                if (rsp_bus.remaining_ms !== exp_r.ms)
                begin
                    $error("remaining_ms expected %0d actual %0d", exp_r.ms, rsp_bus.remaining_ms);
                    fail_count++;
                end
                if (rsp_bus.cache_valid !== exp_r.cv)
                begin
                    $error("cache_valid expected %0b actual %0b", exp_r.cv, rsp_bus.cache_valid);
                    fail_count++;
                end
                if (rsp_bus.build_busy !== exp_r.bb)
                begin
                    $error("build_busy expected %0b actual %0b", exp_r.bb, rsp_bus.build_busy);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        rsp_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_pending = 0;
                rsp_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                rsp_bus.ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
                rsp_bus.ready <= 1'b1;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #50ms;
        $display("range_time_estimate_block_prefix verification failed");
        $finish;
    end

    initial
    begin
        dir_row_t rows [$];
        dir_row_t r;
        int unsigned n;
        int unsigned steps;
        int cnt;
        int k;
        rst_n = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data = '0;
        req_bus.valid = 1'b0;
        req_bus.op = rte_pkg::OP_WRITE;
        req_bus.word_index = '0;
        req_bus.bonus_ms = '0;
        req_bus.start_index = '0;
        req_bus.end_index = '0;
        fail_count = 0;
        quiet = 0;
        hold_pending = 0;
        cur_wc = rte_pkg::WC_RESET;
        cur_wpm = rte_pkg::WPM_RESET;
        cur_acc = 1;
        clear_table();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        rows.push_back('{0, 0, 0, rte_pkg::OP_QUERY, 0, 0, 0, 10, 1, '{0, 0, 0}});
        rows.push_back('{0, 0, 0, OP_SPARE_LO, 0, 0, 0, 10, 1, '{0, 0, 0}});
        rows.push_back('{0, 0, 0, OP_SPARE_HI, 0, 0, 0, 10, 1, '{0, 0, 0}});
        rows.push_back('{0, 0, 0, rte_pkg::OP_START, 0, 0, 0, 0, 1, '{0, 0, 0}});
        rows.push_back('{0, 0, 0, rte_pkg::OP_STEP, 0, 0, 0, 0, 1, '{0, 0, 0}});
        rows.push_back('{1, rte_pkg::REG_WORD_COUNT, 800, rte_pkg::OP_WRITE, 0, 0, 0, 0, 0,
                         '{0, 0, 0}});
        rows.push_back('{0, 0, 0, rte_pkg::OP_START, 0, 0, 0, 0, 1, '{0, 0, 1}});
        rows.push_back('{0, 0, 0, rte_pkg::OP_STEP, 0, 0, 0, 0, 1, '{0, 0, 1}});
        rows.push_back('{0, 0, 0, rte_pkg::OP_STEP, 0, 0, 0, 0, 1, '{0, 0, 1}});
        rows.push_back('{0, 0, 0, rte_pkg::OP_STEP, 0, 0, 0, 0, 1, '{0, 0, 1}});
        rows.push_back('{0, 0, 0, rte_pkg::OP_STEP, 0, 0, 0, 0, 1, '{0, 1, 0}});
        rows.push_back('{0, 0, 0, rte_pkg::OP_QUERY, 0, 0, 0, 1000, 0, '{0, 0, 0}});
        rows.push_back('{0, 0, 0, rte_pkg::OP_QUERY, 0, 0, 10, 900, 0, '{0, 0, 0}});
        rows.push_back('{0, 0, 0, rte_pkg::OP_QUERY, 0, 0, 900, 10, 1, '{0, 1, 0}});
        rows.push_back('{0, 0, 0, rte_pkg::OP_QUERY, 0, 0, 0, 17'h1FFFF, 0, '{0, 0, 0}});
        rows.push_back('{0, 0, 0, rte_pkg::OP_QUERY, 0, 0, 17'h1FFFF, 17'h1FFFF, 1,
                         '{0, 1, 0}});
        rows.push_back('{0, 0, 0, rte_pkg::OP_WRITE, 16'hFFFF, 16'hFFFF, 0, 0, 1, '{0, 1, 0}});
        rows.push_back('{0, 0, 0, rte_pkg::OP_WRITE, 5, 0, 0, 0, 1, '{0, 1, 0}});
        rows.push_back('{0, 0, 0, rte_pkg::OP_QUERY, 0, 0, 1, 300, 0, '{0, 0, 0}});
        rows.push_back('{1, rte_pkg::REG_WPM, 0, rte_pkg::OP_WRITE, 0, 0, 0, 0, 0, '{0, 0, 0}});
        rows.push_back('{0, 0, 0, rte_pkg::OP_QUERY, 0, 0, 0, 500, 1, '{0, 1, 0}});
        rows.push_back('{1, rte_pkg::REG_WPM, 300, rte_pkg::OP_WRITE, 0, 0, 0, 0, 0,
                         '{0, 0, 0}});
        rows.push_back('{0, 0, 0, rte_pkg::OP_INVAL, 0, 0, 0, 0, 1, '{0, 0, 0}});
        rows.push_back('{0, 0, 0, rte_pkg::OP_QUERY, 0, 0, 0, 60, 1, '{12000, 0, 0}});
        rows.push_back('{1, rte_pkg::REG_ACCURATE, 0, rte_pkg::OP_WRITE, 0, 0, 0, 0, 0,
                         '{0, 0, 0}});
        rows.push_back('{0, 0, 0, rte_pkg::OP_START, 0, 0, 0, 0, 1, '{0, 0, 0}});
        rows.push_back('{1, rte_pkg::REG_ACCURATE, 1, rte_pkg::OP_WRITE, 0, 0, 0, 0, 0,
                         '{0, 0, 0}});

        k = 0;
        foreach (rows[i])
        begin
            r = rows[i];
            if (r.is_cfg)
            begin
                // Every word the accurate phases can read is filled before the first one.
                if (k == 0)
                begin
                    for (int w = 0; w < FILLED_WORDS; w++)
                        send_req(rte_pkg::OP_WRITE, rte_pkg::WIDX_W'(w),
                                 (w == 0) ? 16'h0 : (w == 1) ? 16'hFFFF
                                                             : rte_pkg::BONUS_W'($urandom),
                                 0, 0, 0, '0);
                    k = 1;
                end
                drain();
                write_reg(r.idx, r.data);
            end
            else
            begin
                send_req(r.op, r.widx, r.bonus, r.s, r.e, r.typed, r.want);
            end
        end

        for (int ph = 0; ph < 12; ph++)
        begin
            drain();
            quiet = (ph >= 10);
            if (ph % 3 == 2)
            begin
                write_reg(rte_pkg::REG_ACCURATE, 0);
                case ($urandom_range(0, 2))
                    0: write_reg(rte_pkg::REG_WORD_COUNT, 17'd65536);
                    1: write_reg(rte_pkg::REG_WORD_COUNT, 17'h1FFFF);
                    default: write_reg(rte_pkg::REG_WORD_COUNT,
                                       rte_pkg::CFG_DATA_W'($urandom));
                endcase
            end
            else
            begin
                write_reg(rte_pkg::REG_ACCURATE, 1);
                case ($urandom_range(0, 6))
                    0: write_reg(rte_pkg::REG_WORD_COUNT, 0);
                    1: write_reg(rte_pkg::REG_WORD_COUNT, 1);
                    2: write_reg(rte_pkg::REG_WORD_COUNT, 256);
                    3: write_reg(rte_pkg::REG_WORD_COUNT, 257);
                    4: write_reg(rte_pkg::REG_WORD_COUNT, rte_pkg::CFG_DATA_W'(FILLED_WORDS));
                    default: write_reg(rte_pkg::REG_WORD_COUNT,
                                       rte_pkg::CFG_DATA_W'($urandom_range(1, FILLED_WORDS)));
                endcase
            end
            case ($urandom_range(0, 5))
                0: write_reg(rte_pkg::REG_WPM, 0);
                1: write_reg(rte_pkg::REG_WPM, 1);
                2: write_reg(rte_pkg::REG_WPM, 16'hFFFF);
                3: write_reg(rte_pkg::REG_WPM, 300);
                default: write_reg(rte_pkg::REG_WPM,
                                   rte_pkg::CFG_DATA_W'($urandom_range(1, 65535)));
            endcase
            if (ph == 3)
                hold_pending = 1;
            cnt = 0;
            while (cnt < 20)
            begin
                if (ph == 5 && cnt == 10)
                    drain();
                case ($urandom_range(0, 9))
                    0, 1:
                    begin
                        send_req(rte_pkg::OP_START, 0, 0, 0, 0, 0, '0);
                        n = eff_words();
                        steps = (n + BLK - 1) / BLK + 1;
                        if ($urandom_range(0, 3) == 0)
                            steps = $urandom_range(0, steps);
                        for (int j = 0; j < steps; j++)
                        begin
                            if ($urandom_range(0, 2) == 0)
                            begin
                                send_rand($urandom_range(0, 1) ? rte_pkg::OP_QUERY
                                                               : rte_pkg::OP_WRITE);
                                cnt++;
                            end
                            send_req(rte_pkg::OP_STEP, 0, 0, 0, 0, 0, '0);
                            cnt++;
                        end
                        cnt++;
                    end
                    2, 3, 4: begin send_rand(rte_pkg::OP_WRITE); cnt++; end
                    5, 6, 7, 8: begin send_rand(rte_pkg::OP_QUERY); cnt++; end
                    default:
                    begin
                        case ($urandom_range(0, 2))
                            0: send_rand(rte_pkg::OP_INVAL);
                            1: send_rand(rte_pkg::OP_STEP);
                            default: send_rand(rte_pkg::OP_W'($urandom_range(OP_SPARE_LO,
                                                                             OP_SPARE_HI)));
                        endcase
                        cnt++;
                    end
                endcase
            end
        end

        drain();
        repeat (600) @(negedge clk);
        if (fail_count == 0 && pending_estimates.size() == 0)
            $display("range_time_estimate_block_prefix verification clean");
        else
            $display("range_time_estimate_block_prefix verification failed");
        $finish;
    end
endmodule

// ===== range_time_estimate_block_prefix.f =====
design/rte_pkg.sv
design/rte_req_if.sv
design/rte_rsp_if.sv
design/rte_cfg_if.sv
design/rte_div.sv
design/range_time_estimate_block_prefix.sv
dv/range_time_estimate_block_prefix_test.sv
